// ----- hdl/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none

package b64e_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned SextetW  = 6;
  localparam int unsigned GroupW   = 3 * ByteW;
  localparam int unsigned CharsPerGroup = 4;
  localparam int unsigned IdxW     = $clog2(CharsPerGroup);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] PadChar = 7'h3D;

  // Number of '=' characters closing a group
  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_TWO  = 2'd2
  } pad_t;

  // One group of up to three bytes, with its padding, handed from front to back
  typedef struct packed {
    logic [GroupW-1:0] word;
    pad_t              pads;
    logic              last;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CharW-1:0] sextet_to_char(input logic [SextetW-1:0] s);
    logic [CharW-1:0] ch;
    if (s < 6'd26) begin
      ch = 7'h41 + {1'b0, s};
    end else if (s < 6'd52) begin
      ch = 7'h61 + {1'b0, s} - 7'd26;
    end else if (s < 6'd62) begin
      ch = 7'h30 + {1'b0, s} - 7'd52;
    end else if (s == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/b64e_front.sv -----
// Front end: accepts raw bytes, holds up to two pending bytes and forms groups.
// Depends on b64e_pkg.
`default_nettype none

module b64e_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [b64e_pkg::ByteW-1:0] in_tdata,  // [7:0] data_byte
  input  wire logic                       in_tlast,  // last_byte
  input  wire b64e_pkg::q_stat_t          q_stat,
  output logic                            push,
  output b64e_pkg::group_t                push_grp
);

  logic [1:0]                  cnt_r, cnt_nxt;
  logic [b64e_pkg::ByteW-1:0]  hi_r, hi_nxt;
  logic [b64e_pkg::ByteW-1:0]  lo_r, lo_nxt;
  logic                        accept;
  logic                        complete;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign complete  = in_tlast || (cnt_r >= 2'd2);
  assign push      = accept && complete;

  always_comb begin
    push_grp.last = in_tlast;
    case (cnt_r)
      2'd0: begin
        push_grp.word = {in_tdata, {(2 * b64e_pkg::ByteW){1'b0}}};
        push_grp.pads = b64e_pkg::PAD_TWO;
      end
      2'd1: begin
        push_grp.word = {hi_r, in_tdata, {b64e_pkg::ByteW{1'b0}}};
        push_grp.pads = b64e_pkg::PAD_ONE;
      end
      default: begin
        push_grp.word = {hi_r, lo_r, in_tdata};
        push_grp.pads = b64e_pkg::PAD_NONE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    if (accept) begin
      if (complete) begin
        cnt_nxt = 2'd0;
      end else if (cnt_r == 2'd0) begin
        hi_nxt  = in_tdata;
        cnt_nxt = 2'd1;
      end else begin
        lo_nxt  = in_tdata;
        cnt_nxt = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("pending byte count out of range");

endmodule

`default_nettype wire

// ----- hdl/b64e_queue.sv -----
// Two-entry group queue between the front and back ends.
// Depends on b64e_pkg.
`default_nettype none

module b64e_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire b64e_pkg::group_t push_grp,
  input  wire logic             pop,
  output b64e_pkg::group_t      head_grp,
  output b64e_pkg::q_stat_t     q_stat
);

  b64e_pkg::group_t             slot_r [b64e_pkg::QDepth];
  logic [b64e_pkg::QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [b64e_pkg::QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [b64e_pkg::QCntW-1:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == b64e_pkg::QCntW'(b64e_pkg::QDepth));
  assign q_stat.empty = (cnt_r == '0);
  assign head_grp     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_grp;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
    else $error("group queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
    else $error("group queue underflow");

endmodule

`default_nettype wire

// ----- hdl/b64e_back.sv -----
// Back end: takes groups from the queue and sends four characters, one per transfer.
// Depends on b64e_pkg.
`default_nettype none

module b64e_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire b64e_pkg::group_t      head_grp,
  input  wire b64e_pkg::q_stat_t     q_stat,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // [6:0] code_char, [7] zero fill
  output logic                       out_tlast   // last_char
);

  b64e_pkg::group_t              grp_r, grp_nxt;
  logic                          busy_r, busy_nxt;
  logic [b64e_pkg::IdxW-1:0]     idx_r, idx_nxt;
  logic                          xfer;
  logic                          final_char;
  logic                          is_pad;
  logic [b64e_pkg::SextetW-1:0]  sextet;
  logic [b64e_pkg::CharW-1:0]    ch;

  assign xfer       = out_tvalid && out_tready;
  assign final_char = (idx_r == b64e_pkg::IdxW'(b64e_pkg::CharsPerGroup - 1));
  // load a fresh group when idle or as the fourth character leaves
  assign pop        = !q_stat.empty && (!busy_r || (xfer && final_char));

  always_comb begin
    sextet = grp_r.word[b64e_pkg::GroupW - 1 - b64e_pkg::SextetW * idx_r -: b64e_pkg::SextetW];
    is_pad = ((grp_r.pads == b64e_pkg::PAD_TWO) && (idx_r >= 2'd2)) ||
             ((grp_r.pads == b64e_pkg::PAD_ONE) && final_char);
    ch     = is_pad ? b64e_pkg::PadChar : b64e_pkg::sextet_to_char(sextet);
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {1'b0, ch};
  assign out_tlast  = grp_r.last && final_char;

  always_comb begin
    grp_nxt  = grp_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      grp_nxt  = head_grp;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (xfer) begin
      idx_nxt = idx_r + 1'b1;
      if (final_char) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && final_char && q_stat.empty) |=> !busy_r)
    else $error("back end stayed busy after its last character");

  a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !q_stat.empty) |=> (busy_r && idx_r == '0))
    else $error("back end did not pick up a waiting group");

endmodule

`default_nettype wire

// ----- hdl/base64_stream_encoder.sv -----
// Top level of the base64 stream encoder: front end, group queue and back end.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
`default_nettype none

// Standard base64 encoder for a byte stream. Bytes enter on in_* with in_tlast on
// the final byte of a message; each group of three bytes, or the short group that
// ends a message, leaves as four ASCII characters on out_*, one per transfer, with
// '=' padding and out_tlast on the fourth character of the closing group. The
// front end never waits for the output while the two-entry group queue has room.
// Sustained throughput is set by the back end, which sends one character per cycle
// while out_tready stays high and takes the next waiting group as the fourth
// character of the last one leaves. A completed group is written into the queue,
// then loaded into the back end's group register before its first character.
module base64_stream_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] code_char, [7] zero fill
  output logic            out_tlast   // last_char
);

  b64e_pkg::q_stat_t q_stat;
  b64e_pkg::group_t  push_grp;
  b64e_pkg::group_t  head_grp;
  logic              push;
  logic              pop;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_grp  (push_grp)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head_grp (head_grp),
    .q_stat   (q_stat)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_grp   (head_grp),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_base64_stream_encoder.sv -----
// Self-checking testbench for base64_stream_encoder: byte messages in, characters out.
// Predicts every character from its own encoder model; depends on b64e_pkg and the RTL.
`default_nettype none

module tb_base64_stream_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 12;

  typedef struct {
    logic [b64e_pkg::ByteW-1:0] data;
    logic                       last;
  } msg_byte_t;

  typedef struct {
    logic [b64e_pkg::CharW-1:0] code;
    logic                       last;
  } code_char_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;  // [7:0] data_byte
  logic             in_tlast   = 1'b0;   // last_byte
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;           // [6:0] code_char, [7] zero fill
  logic             out_tlast;           // last_char

  msg_byte_t   byte_queue[$];
  code_char_t  expected_chars[$];
  msg_byte_t   next_byte;
  code_char_t  want;

  // Encoder state as the predictor sees it
  logic [b64e_pkg::ByteW-1:0] held_first  = '0;
  logic [b64e_pkg::ByteW-1:0] held_second = '0;
  logic [1:0]                 held_count  = '0;

  string b64_symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  base64_stream_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // Work out the characters released by one accepted byte
  function automatic void encode_byte(logic [b64e_pkg::ByteW-1:0] b, logic last);
    logic [23:0] word;
    logic [5:0]  sextet;
    int          pads;
    code_char_t  ch;
    if (!last && held_count == 2'd0) begin
      held_first = b;
      held_count = 2'd1;
      return;
    end
    if (!last && held_count == 2'd1) begin
      held_second = b;
      held_count  = 2'd2;
      return;
    end
    case (held_count)
      2'd0: begin
        word = {b, 16'h0000};
        pads = 2;
      end
      2'd1: begin
        word = {held_first, b, 8'h00};
        pads = 1;
      end
      default: begin
        word = {held_first, held_second, b};
        pads = 0;
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      sextet = 6'((word >> (18 - 6 * k)) & 24'h3F);
      ch.code = (k >= 4 - pads) ? b64e_pkg::PadChar :
                                  b64e_pkg::CharW'(b64_symbols[sextet]);
      ch.last = last && (k == 3);
      expected_chars.push_back(ch);
    end
    held_first  = '0;
    held_second = '0;
    held_count  = 2'd0;
  endfunction

  // Sender: offer the next queued byte, or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = byte_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.data;
        in_tlast  <= next_byte.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check the output transfer first, then predict from the input transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: code_char %h last_char %b", out_tdata[6:0], out_tlast);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[6:0] !== want.code) begin
          $error("code_char: expected %h, got %h", want.code, out_tdata[6:0]);
          error_count++;
        end
        if (out_tdata[7] !== 1'b0) begin
          $error("tdata fill: expected 0, got %b", out_tdata[7]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_char: expected %b, got %b", want.last, out_tlast);
          error_count++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) encode_byte(in_tdata, in_tlast);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] data, logic last);
    msg_byte_t item;
    item.data = data;
    item.last = last;
    byte_queue.push_back(item);
  endtask

  task automatic push_message(int len);
    for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
  endtask

  // Mostly short messages so every padding case recurs, some longer runs
  task automatic push_random_traffic(int n_bytes);
    int queued;
    int len;
    queued = 0;
    while (queued < n_bytes) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 4);
      push_message(len);
      queued += len;
    end
  endtask

  // Hold until every byte is taken and every character has come back
  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_tvalid || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One-byte messages, two '=' each
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // Two-byte message, one '='
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFE, 1'b1);
    // Full groups: all '+', all '/'
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    // Last mark on a full second group, no padding; then a two-byte message
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h4D, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h6E, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b1);
    // Four bytes: one full group then a short one
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b1);
    wait_drained();

    push_random_traffic(20);
    wait_drained();

    set_idling(85, 0);
    push_random_traffic(20);
    wait_drained();

    set_idling(0, 85);
    push_random_traffic(20);
    wait_drained();

    set_idling(20, 20);
    push_random_traffic(20);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering full groups
    set_idling(0, 0);
    hold_req = 1'b1;
    while (hold_left == 0) @(negedge clk);
    hold_req = 1'b0;
    for (int m = 0; m < 8; m++) push_message(3);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
